[hdl/cmd_pkg.sv]
// Shared types and constants for the cosine minimum-distance block.
package cmd_pkg;

  localparam int LANES     = 4;
  localparam int ELEM_W    = 16;
  localparam int PROD_W    = 2 * ELEM_W;
  localparam int ACC_W     = 48;
  localparam int HALF_W    = ACC_W / 2;
  localparam int NORM_W    = 2 * ACC_W;
  localparam int WIDE_W    = 128;
  localparam int FRAC_BITS = 15;
  localparam int SIM_W     = 16;
  localparam int BIT_W     = 4;
  localparam int STEP_W    = 4;
  localparam int QDEPTH    = 4;
  localparam int QPTR_W    = $clog2(QDEPTH);
  localparam int QCNT_W    = $clog2(QDEPTH + 1);

  localparam logic [SIM_W-1:0] ONE_Q15  = SIM_W'(1 << FRAC_BITS);
  localparam logic [BIT_W-1:0] TOP_BIT  = BIT_W'(FRAC_BITS - 1);
  localparam logic [STEP_W-1:0] MUL_STEPS = STEP_W'(8);

  typedef struct packed {
    logic [ACC_W-1:0] dot;
    logic [ACC_W-1:0] det_sq;
    logic [ACC_W-1:0] trk_sq;
    logic             eot;
  } vec_t;

  typedef struct packed {
    logic nonempty;
    logic nearly_full;
  } queue_stat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_TOP,
    ST_BITS,
    ST_UPD
  } back_state_t;

endpackage

[hdl/cosine_min_distance.sv]
// Top level: cosine minimum distance between one detection and a run of tracks.
// Element groups are taken one per cycle while the vector queue has room.
// Each vector end passes the search unit through the multiply steps, a clamp check,
// 15 bit trials and control; the bit trials are skipped when the similarity clamps
// to 1.0, and the search is skipped when the similarity is trivially zero.
// Synchronous active-low reset clears accumulators, best similarity and queue.
module cosine_min_distance import cmd_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [ELEM_W-1:0] in_det_0,
  input  logic signed [ELEM_W-1:0] in_det_1,
  input  logic signed [ELEM_W-1:0] in_det_2,
  input  logic signed [ELEM_W-1:0] in_det_3,
  input  logic signed [ELEM_W-1:0] in_trk_0,
  input  logic signed [ELEM_W-1:0] in_trk_1,
  input  logic signed [ELEM_W-1:0] in_trk_2,
  input  logic signed [ELEM_W-1:0] in_trk_3,
  input  logic                     in_end_of_vector,
  input  logic                     in_end_of_tracks,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [SIM_W-1:0]         out_distance
);

  logic signed [ELEM_W-1:0] det [LANES];
  logic signed [ELEM_W-1:0] trk [LANES];
  logic        push, pop;
  vec_t        push_data, head;
  queue_stat_t stat;

  assign det[0] = in_det_0;
  assign det[1] = in_det_1;
  assign det[2] = in_det_2;
  assign det[3] = in_det_3;
  assign trk[0] = in_trk_0;
  assign trk[1] = in_trk_1;
  assign trk[2] = in_trk_2;
  assign trk[3] = in_trk_3;

  assign in_stall = stat.nearly_full;

  cmd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .det       (det),
    .trk       (trk),
    .eov       (in_end_of_vector),
    .eot       (in_end_of_tracks),
    .push      (push),
    .push_data (push_data)
  );

  cmd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .stat      (stat)
  );

  cmd_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .head         (head),
    .stat         (stat),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_distance (out_distance)
  );

endmodule

[hdl/cmd_front.sv]
// Front end: accepts element groups, forms lane products and accumulates per vector.
module cmd_front import cmd_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic                     in_stall,
  input  logic signed [ELEM_W-1:0] det [LANES],
  input  logic signed [ELEM_W-1:0] trk [LANES],
  input  logic                     eov,
  input  logic                     eot,
  output logic                     push,
  output vec_t                     push_data
);

  logic                     s1_vld_r;
  logic                     s1_eov_r;
  logic                     s1_eot_r;
  logic signed [PROD_W-1:0] dt_r [LANES];
  logic signed [PROD_W-1:0] dd_r [LANES];
  logic signed [PROD_W-1:0] tt_r [LANES];
  logic [ACC_W-1:0]         dot_r, dsq_r, tsq_r;
  logic [ACC_W-1:0]         dot_sum, dsq_sum, tsq_sum;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= in_valid && !in_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_eov_r <= eov;
      s1_eot_r <= eot;
      for (int i = 0; i < LANES; i++) begin
        dt_r[i] <= det[i] * trk[i];
        dd_r[i] <= det[i] * det[i];
        tt_r[i] <= trk[i] * trk[i];
      end
    end
  end

  always_comb begin
    dot_sum = dot_r;
    dsq_sum = dsq_r;
    tsq_sum = tsq_r;
    for (int i = 0; i < LANES; i++) begin
      dot_sum = dot_sum + ACC_W'(dt_r[i]);
      dsq_sum = dsq_sum + ACC_W'(dd_r[i]);
      tsq_sum = tsq_sum + ACC_W'(tt_r[i]);
    end
  end

  assign push             = s1_vld_r && s1_eov_r;
  assign push_data.dot    = dot_sum;
  assign push_data.det_sq = dsq_sum;
  assign push_data.trk_sq = tsq_sum;
  assign push_data.eot    = s1_eot_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dot_r <= '0;
      dsq_r <= '0;
      tsq_r <= '0;
    end else if (s1_vld_r) begin
      if (s1_eov_r) begin
        dot_r <= '0;
        dsq_r <= '0;
        tsq_r <= '0;
      end else begin
        dot_r <= dot_sum;
        dsq_r <= dsq_sum;
        tsq_r <= tsq_sum;
      end
    end
  end

endmodule

[hdl/cmd_queue.sv]
// Short queue of finished vector sums between front and back.
module cmd_queue import cmd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  vec_t        push_data,
  input  logic        pop,
  output vec_t        head,
  output queue_stat_t stat
);

  vec_t              slot_r [QDEPTH];
  logic [QPTR_W-1:0] wr_r, rd_r;
  logic [QCNT_W-1:0] cnt_r;

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= wr_r + QPTR_W'(1);
      if (pop)  rd_r <= rd_r + QPTR_W'(1);
      if (push && !pop)      cnt_r <= cnt_r + QCNT_W'(1);
      else if (pop && !push) cnt_r <= cnt_r - QCNT_W'(1);
    end
  end

  assign head             = slot_r[rd_r];
  assign stat.nonempty    = cnt_r != '0;
  assign stat.nearly_full = cnt_r >= QCNT_W'(QDEPTH - 1);

endmodule

[hdl/cmd_back.sv]
// Back end: per-vector similarity search, best tracking and distance output.
module cmd_back import cmd_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  vec_t             head,
  input  queue_stat_t      stat,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [SIM_W-1:0] out_distance
);

  back_state_t       state_r, state_nxt;
  logic [ACC_W-1:0]  xy_r, xy_nxt, xx_r, xx_nxt, yy_r, yy_nxt;
  logic              eot_r, eot_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [ACC_W-1:0]  prod_r, prod_nxt;
  logic [2:0]        psel_r, psel_nxt;
  logic              pvld_r, pvld_nxt;
  logic [NORM_W-1:0] n_r, n_nxt;
  logic [WIDE_W-1:0] r_r, r_nxt, p_r, p_nxt, q_r, q_nxt;
  logic [SIM_W-1:0]  s_r, s_nxt, best_r, best_nxt, dist_r, dist_nxt;
  logic [BIT_W-1:0]  k_r, k_nxt;
  logic              ovld_r, ovld_nxt;

  logic [ACC_W-1:0]  op_a, op_b;
  logic [HALF_W-1:0] half_a, half_b;
  logic [1:0]        hsum;
  logic [WIDE_W-1:0] prod_sh, n_ext, trial;
  logic [SIM_W-1:0]  best_max;
  logic              zero_sim;

  assign op_a   = step_r[2] ? xy_r : xx_r;
  assign op_b   = step_r[2] ? xy_r : yy_r;
  assign half_a = step_r[1] ? op_a[ACC_W-1:HALF_W] : op_a[HALF_W-1:0];
  assign half_b = step_r[0] ? op_b[ACC_W-1:HALF_W] : op_b[HALF_W-1:0];
  assign hsum   = {1'b0, psel_r[1]} + {1'b0, psel_r[0]};
  assign n_ext  = WIDE_W'(n_r);
  assign trial  = p_r + (q_r << ({1'b0, k_r} + 5'd1)) + (n_ext << {k_r, 1'b0});
  assign best_max = (s_r > best_r) ? s_r : best_r;
  assign zero_sim = (head.det_sq == '0) || (head.trk_sq == '0) || (head.dot == '0) ||
                    head.dot[ACC_W-1];

  always_comb begin
    case (hsum)
      2'd0:    prod_sh = WIDE_W'(prod_r);
      2'd1:    prod_sh = WIDE_W'(prod_r) << HALF_W;
      default: prod_sh = WIDE_W'(prod_r) << (2 * HALF_W);
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    xy_nxt    = xy_r;
    xx_nxt    = xx_r;
    yy_nxt    = yy_r;
    eot_nxt   = eot_r;
    step_nxt  = step_r;
    psel_nxt  = step_r[2:0];
    pvld_nxt  = 1'b0;
    prod_nxt  = prod_r;
    n_nxt     = n_r;
    r_nxt     = r_r;
    p_nxt     = p_r;
    q_nxt     = q_r;
    s_nxt     = s_r;
    k_nxt     = k_r;
    best_nxt  = best_r;
    dist_nxt  = dist_r;
    ovld_nxt  = ovld_r && out_stall;
    pop       = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (stat.nonempty) begin
          pop     = 1'b1;
          xy_nxt  = head.dot;
          xx_nxt  = head.det_sq;
          yy_nxt  = head.trk_sq;
          eot_nxt = head.eot;
          if (zero_sim) begin
            s_nxt     = '0;
            state_nxt = ST_UPD;
          end else begin
            n_nxt     = '0;
            r_nxt     = '0;
            step_nxt  = '0;
            state_nxt = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        // one 24x24 partial product per cycle, summed in on the next
        if (!step_r[STEP_W-1]) begin
          step_nxt = step_r + STEP_W'(1);
          pvld_nxt = 1'b1;
          prod_nxt = ACC_W'(half_a) * ACC_W'(half_b);
        end
        if (pvld_r) begin
          if (psel_r[2]) r_nxt = r_r + (prod_sh << (2 * FRAC_BITS));
          else           n_nxt = n_r + NORM_W'(prod_sh);
        end
        if (step_r == MUL_STEPS) state_nxt = ST_TOP;
      end
      ST_TOP: begin
        if ((n_ext << (2 * FRAC_BITS)) <= r_r) begin
          s_nxt     = ONE_Q15;
          state_nxt = ST_UPD;
        end else begin
          s_nxt     = '0;
          p_nxt     = '0;
          q_nxt     = '0;
          k_nxt     = TOP_BIT;
          state_nxt = ST_BITS;
        end
      end
      ST_BITS: begin
        // p = s*s*N, q = s*N
        if (trial <= r_r) begin
          s_nxt = s_r | (SIM_W'(1) << k_r);
          p_nxt = trial;
          q_nxt = q_r + (n_ext << k_r);
        end
        k_nxt = k_r - BIT_W'(1);
        if (k_r == '0) state_nxt = ST_UPD;
      end
      ST_UPD: begin
        if (!eot_r) begin
          best_nxt  = best_max;
          state_nxt = ST_IDLE;
        end else if (!ovld_r || !out_stall) begin
          ovld_nxt  = 1'b1;
          dist_nxt  = ONE_Q15 - best_max;
          best_nxt  = '0;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pvld_r  <= 1'b0;
      best_r  <= '0;
      ovld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pvld_r  <= pvld_nxt;
      best_r  <= best_nxt;
      ovld_r  <= ovld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    xy_r   <= xy_nxt;
    xx_r   <= xx_nxt;
    yy_r   <= yy_nxt;
    eot_r  <= eot_nxt;
    step_r <= step_nxt;
    psel_r <= psel_nxt;
    prod_r <= prod_nxt;
    n_r    <= n_nxt;
    r_r    <= r_nxt;
    p_r    <= p_nxt;
    q_r    <= q_nxt;
    s_r    <= s_nxt;
    k_r    <= k_nxt;
    dist_r <= dist_nxt;
  end

  assign out_valid    = ovld_r;
  assign out_distance = dist_r;

endmodule
